@@ hdl/trial_division_prime_test_core_defines.svh @@
// assertion macros for the trial division prime test core
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tdp_pkg.sv @@
// shared constants and sequencer state type for the prime test core
// no dependencies
`timescale 1ns / 1ps

package tdp_pkg;

	localparam int VALUE_BITS = 20;
	// trial divisors never exceed floor(sqrt(n)) + 1
	localparam int DIV_BITS = VALUE_BITS / 2 + 1;
	// running square of the divisor
	localparam int SQ_BITS = VALUE_BITS + 1;
	// index of the candidate bit fed into the remainder step
	localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} tdp_state_t;

endpackage

@@ hdl/trial_division_prime_test_core.sv @@
// trial division primality test, one shared restoring remainder unit
// depends on tdp_pkg and trial_division_prime_test_core_defines.svh
`timescale 1ns / 1ps
`include "trial_division_prime_test_core_defines.svh"

//  channel | signals                      | direction
//  in      | in_valid in_ready candidate   | request into the core
//  out     | out_valid out_ready is_prime  | result out of the core
//
// candidates 0 and 1 finish in the cycle after the request is taken
// other candidates: per divisor d = 2, 3, ... a check state (d*d > n ends with prime)
// then a divide state that walks all VALUE_BITS candidate bits through the remainder
// the remainder unit shifts in one candidate bit per cycle and is the limiting loop
// in_ready is high only while idle; a result waits in its register until out_ready
// asynchronous reset clears the sequencer only, there is no stored table to clear

module trial_division_prime_test_core
	import tdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_prime
);

	tdp_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] n_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]   bit_q;
	logic                  prime_q;

	logic                  in_fire;
	logic                  small_in;
	logic                  sq_over;
	logic [DIV_BITS:0]     trial;
	logic                  trial_ge;
	logic [DIV_BITS-1:0]   rem_next;
	logic                  last_bit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign is_prime  = prime_q;
	assign in_fire   = in_valid && in_ready;
	assign small_in  = (candidate < VALUE_BITS'(2));

	// shared remainder step: shift in one candidate bit, subtract divisor if it fits
	assign trial    = {rem_q, n_q[bit_q]};
	assign trial_ge = (trial >= {1'b0, div_q});
	assign rem_next = trial_ge ? DIV_BITS'(trial - {1'b0, div_q}) : DIV_BITS'(trial);
	assign last_bit = (bit_q == CNT_BITS'(0));
	assign sq_over  = (sq_q > {1'b0, n_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = small_in ? ST_DONE : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sq_over ? ST_DONE : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (last_bit) begin
					state_d = (rem_next == '0) ? ST_DONE : ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					n_q     <= candidate;
					div_q   <= DIV_BITS'(2);
					sq_q    <= SQ_BITS'(4);
					prime_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				rem_q <= '0;
				bit_q <= CNT_BITS'(VALUE_BITS - 1);
				if (sq_over) begin
					prime_q <= 1'b1;
				end
			end
			ST_DIVIDE: begin
				rem_q <= rem_next;
				bit_q <= bit_q - CNT_BITS'(1);
				if (last_bit) begin
					if (rem_next == '0) begin
						prime_q <= 1'b0;
					end else begin
						// (d+1)^2 = d^2 + 2d + 1
						div_q <= div_q + DIV_BITS'(1);
						sq_q  <= sq_q + SQ_BITS'({div_q, 1'b1});
					end
				end
			end
			default: begin
			end
		endcase
	end

	// busy (check or divide) is exactly neither ready nor holding a result
	`TDP_ASSERT_NOW(a_ready_result_excl, in_ready, !out_valid, "ready while result held")
	`TDP_ASSERT_NEXT(a_small_flag, in_fire && small_in, out_valid && !is_prime, "bad small flag")
	`TDP_ASSERT_NOW(a_rem_below_div, state_q == ST_DIVIDE, rem_q < div_q, "remainder overflow")
	`TDP_ASSERT_NOW(a_div_floor, !in_ready && !out_valid, div_q >= DIV_BITS'(2), "low divisor")

endmodule

@@ sim/prime_flag_checker.sv @@
// watches both channels of the prime test core, predicts each flag and compares
// depends on tdp_pkg; reports open requests and errors to the testbench top
`timescale 1ns / 1ps

module prime_flag_checker
	import tdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  is_prime,
	output int                    open_requests,
	output int                    error_count
);

	logic expected_flags[$];

	function automatic logic prime_flag(input logic [VALUE_BITS-1:0] n);
		longint unsigned value;
		longint unsigned divisor;
		value = 64'(n);
		if (value < 2)
			return 1'b0;
		// a composite always has a factor no larger than its square root
		for (divisor = 2; divisor <= value / 2 && divisor * divisor <= value; divisor++) begin
			if (value % divisor == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		int   delta;
		if (!arst_n) begin
			expected_flags.delete();
			open_requests <= 0;
			error_count <= 0;
		end else begin
			delta = 0;
			// pop before push so a result never matches the request taken at the same edge
			if (out_valid && out_ready) begin
				if (expected_flags.size() == 0) begin
					$error("is_prime: result with no request waiting, actual %0b", is_prime);
					error_count <= error_count + 1;
				end else begin
					want = expected_flags.pop_front();
					delta--;
					if (is_prime !== want) begin
						$error("is_prime mismatch: expected %0b, actual %0b", want, is_prime);
						error_count <= error_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_flags.push_back(prime_flag(candidate));
				delta++;
			end
			open_requests <= open_requests + delta;
		end
	end

endmodule

@@ sim/testbench.sv @@
// stimulus and verdict for trial_division_prime_test_core
// depends on tdp_pkg, the core and prime_flag_checker
`timescale 1ns / 1ps

module testbench;
	import tdp_pkg::*;

	localparam int RANDOM_ITEMS = 580;
	localparam int CALM_ITEMS = 60;
	localparam int CORNER_ITEMS = 22;

	localparam logic [VALUE_BITS-1:0] CORNER [CORNER_ITEMS] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 49, 97, 121, 1021,
		4093,      // largest 12-bit prime
		65521,     // largest 16-bit prime
		1042441,   // 1021 squared, divisor hits the square root exactly
		1040399,   // 1019 * 1021
		1048573,   // largest prime in range, longest search
		1048575,   // all ones
		699050,    // alternating bits
		349525
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  out_ready = 1'b0;
	logic [VALUE_BITS-1:0] candidate = '0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  is_prime;
	int                    open_requests;
	int                    error_count;
	bit                    calm = 1'b0;
	int                    stall_left = 0;

	always #1 clk = ~clk;

	trial_division_prime_test_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.candidate (candidate),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime)
	);

	prime_flag_checker flag_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.candidate     (candidate),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_prime      (is_prime),
		.open_requests (open_requests),
		.error_count   (error_count)
	);

	// result side backpressure in random bursts of stall, none begun while calm
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left <= int'($urandom_range(0, 17));
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic offer(input logic [VALUE_BITS-1:0] value);
		in_valid <= 1'b1;
		candidate <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// hold off new requests until every outstanding flag has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_requests != 0)
			@(posedge clk);
	endtask

	// mostly small candidates, since search time grows with the square root
	function automatic logic [VALUE_BITS-1:0] random_candidate();
		case ($urandom_range(0, 9)) inside
			[0:5]:   return VALUE_BITS'($urandom_range(0, 4095));
			6:       return VALUE_BITS'($urandom_range(0, 65535));
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (CORNER[i]) begin
			offer(CORNER[i]);
			maybe_pause();
		end
		settle();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				settle();
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm <= 1'b1;
			offer(random_candidate());
			maybe_pause();
		end
		settle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tdp_pkg.sv
hdl/trial_division_prime_test_core.sv
sim/prime_flag_checker.sv
sim/testbench.sv
